### hw/rtl/tri_pkg.sv
`timescale 1ns / 1ps
// Shared widths and constants for the triangle-area pipeline.
// No dependencies.
package tri_pkg;
    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS      = 16;
    localparam int AREA_WIDTH     = 64;
    // quotient bits resolved per divider stage
    localparam int DIV_BPS        = 2;
    // front (4) + squaring (2) + divider stages
    localparam int PIPE_LATENCY   = 4 + 2 + (AREA_WIDTH + DIV_BPS) / DIV_BPS;
endpackage

### hw/rtl/tri_front.sv
`timescale 1ns / 1ps
// Front stages: pair cross products, 3x3 determinant, denominator product.
// Depends on tri_pkg.
module tri_front
    import tri_pkg::*;
#(
    parameter int CW = COEF_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] a1, b1, c1, a2, b2, c2, a3, b3, c3,
    output logic                 out_valid,
    output logic                 out_par,
    output logic [4*CW+1:0]      out_num_root,
    output logic [6*CW+3:0]      out_den
);
    localparam int PW = 2*CW + 1;
    localparam int UW = 2*CW;
    localparam int DW = 3*CW + 3;

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [PW-1:0] p12_reg, p13_reg, p23_reg;
    logic signed [CW-1:0] c1_reg, c2_reg, c3_reg;
    logic signed [DW-1:0] det_reg;
    logic [2*UW-1:0]   m1213_reg;
    logic [UW-1:0]     a23_reg;
    logic              par2_reg, par3_reg, par4_reg;
    logic [DW-1:0]     adet3_reg, adet4_reg;
    logic [2*UW-1:0]   dlo_reg, dhi_reg;
    logic [3*UW-1:0]   den_reg;
    logic signed [DW-1:0] det_next;
    logic [UW-1:0]     a12_abs, a13_abs, a23_abs;

    // cross product magnitudes fit in 2*CW bits
    always_comb
    begin
        det_next = DW'(c1_reg * p23_reg) - DW'(c2_reg * p13_reg) + DW'(c3_reg * p12_reg);
        a12_abs  = p12_reg[PW-1] ? UW'(-p12_reg) : UW'(p12_reg);
        a13_abs  = p13_reg[PW-1] ? UW'(-p13_reg) : UW'(p13_reg);
        a23_abs  = p23_reg[PW-1] ? UW'(-p23_reg) : UW'(p23_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p12_reg   <= PW'(a1 * b2) - PW'(a2 * b1);
        p13_reg   <= PW'(a1 * b3) - PW'(a3 * b1);
        p23_reg   <= PW'(a2 * b3) - PW'(a3 * b2);
        c1_reg    <= c1;
        c2_reg    <= c2;
        c3_reg    <= c3;
        det_reg   <= det_next;
        m1213_reg <= a12_abs * a13_abs;
        a23_reg   <= a23_abs;
        par2_reg  <= (p12_reg == '0) || (p13_reg == '0) || (p23_reg == '0);
        // denominator product split in two halves
        dlo_reg   <= m1213_reg[UW-1:0] * a23_reg;
        dhi_reg   <= m1213_reg[2*UW-1:UW] * a23_reg;
        adet3_reg <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        par3_reg  <= par2_reg;
        den_reg   <= ((3*UW)'(dhi_reg) << UW) + (3*UW)'(dlo_reg);
        adet4_reg <= adet3_reg;
        par4_reg  <= par3_reg;
    end

    assign out_valid    = v4_reg;
    assign out_par      = par4_reg;
    assign out_num_root = (4*CW+2)'(adet4_reg);
    assign out_den      = {3'b000, den_reg, 1'b0};
endmodule

### hw/rtl/tri_div.sv
`timescale 1ns / 1ps
// Squaring stages and pipelined restoring divider, a few quotient bits a stage.
// Depends on tri_pkg.
module tri_div
    import tri_pkg::*;
#(
    parameter int CW = COEF_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_par,
    input  logic [4*CW+1:0]   in_root,
    input  logic [6*CW+3:0]   in_den,
    output logic              out_valid,
    output logic [AREA_WIDTH-1:0] out_area,
    output logic              out_par,
    output logic              out_sat
);
    // Quotient bits above AREA_WIDTH only flag saturation; QW = AREA_WIDTH+1.
    localparam int QW   = AREA_WIDTH + 1;
    localparam int NW   = 8*CW + 4 + FRAC_BITS;
    localparam int DENW = 6*CW + 4;
    localparam int RW   = DENW + 1;
    localparam int RH   = 2*CW + 1;
    localparam int SQW  = 4*RH;
    localparam int BPS  = DIV_BPS;
    localparam int NST  = (QW + BPS - 1) / BPS;
    localparam int QT   = NST * BPS;

    logic              qv_reg, qpar_reg;
    logic [2*RH-1:0]   hh_reg, hl_reg, ll_reg;
    logic [DENW-1:0]   qden_reg;
    logic              sv_reg, spar_reg;
    logic [NW-1:0]     num_reg;
    logic [DENW-1:0]   sden_reg;
    logic [SQW-1:0]    sq_sum;
    logic              hi_ovf;

    logic              v_reg   [NST];
    logic              par_reg [NST];
    logic              sat_reg [NST];
    logic [RW-1:0]     rem_reg [NST];
    logic [QT-1:0]     q_reg   [NST];
    logic [QT-1:0]     n_reg   [NST];
    logic [DENW-1:0]   d_reg   [NST];

    // root^2 from three half-width partial products
    always_comb
    begin
        sq_sum = (SQW'(hh_reg) << (2*RH)) + (SQW'(hl_reg) << (RH + 1)) + SQW'(ll_reg);
    end

    always_ff @(posedge clk)
    begin
        hh_reg   <= in_root[2*RH-1:RH] * in_root[2*RH-1:RH];
        hl_reg   <= in_root[2*RH-1:RH] * in_root[RH-1:0];
        ll_reg   <= in_root[RH-1:0] * in_root[RH-1:0];
        qden_reg <= in_den;
        qpar_reg <= in_par;
        num_reg  <= {sq_sum, {FRAC_BITS{1'b0}}};
        sden_reg <= qden_reg;
        spar_reg <= qpar_reg;
    end

    // high part of numerator vs divisor: quotient overflows if high >= den
    always_comb
    begin
        if (NW > QT)
            hi_ovf = (RW'(num_reg >> QT) >= RW'(sden_reg));
        else
            hi_ovf = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else
        begin
            qv_reg <= in_valid;
            sv_reg <= qv_reg;
        end
    end

    genvar s;
    generate
        for (s = 0; s < NST; s++)
        begin : g_st
            logic [RW-1:0] r_in, r_w;
            logic [QT-1:0] q_in, q_w, n_in;
            logic          v_in, p_in, sat_in;
            logic [DENW-1:0] d_in;
            if (s == 0)
            begin : g_head
                assign v_in   = sv_reg;
                assign p_in   = spar_reg;
                assign sat_in = hi_ovf;
                assign r_in   = hi_ovf ? '0 : RW'(num_reg >> QT);
                assign q_in   = '0;
                assign n_in   = QT'(num_reg);
                assign d_in   = sden_reg;
            end
            else
            begin : g_link
                assign v_in   = v_reg[s-1];
                assign p_in   = par_reg[s-1];
                assign sat_in = sat_reg[s-1];
                assign r_in   = rem_reg[s-1];
                assign q_in   = q_reg[s-1];
                assign n_in   = n_reg[s-1];
                assign d_in   = d_reg[s-1];
            end
            always_comb
            begin
                r_w = r_in;
                q_w = q_in;
                for (int k = 0; k < BPS; k++)
                begin
                    r_w = {r_w[RW-2:0], n_in[QT-1-(s*BPS+k)]};
                    q_w = {q_w[QT-2:0], 1'b0};
                    if (r_w >= RW'(d_in))
                    begin
                        r_w    = r_w - RW'(d_in);
                        q_w[0] = 1'b1;
                    end
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[s] <= 1'b0;
                else
                    v_reg[s] <= v_in;
            end
            always_ff @(posedge clk)
            begin
                par_reg[s] <= p_in;
                sat_reg[s] <= sat_in;
                rem_reg[s] <= r_w;
                q_reg[s]   <= q_w;
                n_reg[s]   <= n_in;
                d_reg[s]   <= d_in;
            end
        end
    endgenerate

    logic          fsat;
    logic [QT-1:0] qf;
    assign qf   = q_reg[NST-1];
    assign fsat = !par_reg[NST-1] && (sat_reg[NST-1] || (qf[QT-1:AREA_WIDTH] != '0));

    assign out_valid = v_reg[NST-1];
    assign out_par   = par_reg[NST-1];
    assign out_sat   = fsat;
    assign out_area  = par_reg[NST-1] ? '0 :
                       (fsat ? '1 : qf[AREA_WIDTH-1:0]);
endmodule

### hw/rtl/triangle_area_from_three_lines.sv
`timescale 1ns / 1ps
// Top level: triangle area from three lines, fully pipelined.
// Depends on tri_pkg, tri_front, tri_div.
//
// Usage: drive the nine coefficients and pulse start; busy is always low,
// so one transaction may enter every cycle. Each transaction produces one
// result, shown for exactly one cycle with done high: area (Q48.16,
// truncated), no_triangle (a pair of lines is parallel, area 0) and
// saturated (area clamped to all ones).
// Pipeline: front stages (cross products, determinant and first product,
// split denominator product, denominator sum), squaring stages (partial
// products, then their sum), then ceil(65/2) = 33 divider stages of 2
// quotient bits each. Throughput is one transaction per cycle; the
// pipeline depth sets the latency.
// Reset clears all valid bits; no result appears until a new transaction.
// The receiver cannot stall, so there is no back-pressure path.
module triangle_area_from_three_lines
    import tri_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COEF_WIDTH-1:0] line1_a, line1_b, line1_c,
    input  logic signed [COEF_WIDTH-1:0] line2_a, line2_b, line2_c,
    input  logic signed [COEF_WIDTH-1:0] line3_a, line3_b, line3_c,
    output logic                         done,
    output logic [AREA_WIDTH-1:0]        area,
    output logic                         no_triangle,
    output logic                         saturated
);
    logic                       f_valid, f_par;
    logic [4*COEF_WIDTH+1:0]    f_root;
    logic [6*COEF_WIDTH+3:0]    f_den;

    assign busy = 1'b0;

    tri_front #(.CW(COEF_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start),
        .a1(line1_a), .b1(line1_b), .c1(line1_c),
        .a2(line2_a), .b2(line2_b), .c2(line2_c),
        .a3(line3_a), .b3(line3_b), .c3(line3_c),
        .out_valid(f_valid), .out_par(f_par),
        .out_num_root(f_root), .out_den(f_den)
    );

    tri_div #(.CW(COEF_WIDTH)) u_div (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_par(f_par),
        .in_root(f_root), .in_den(f_den),
        .out_valid(done), .out_area(area),
        .out_par(no_triangle), .out_sat(saturated)
    );

    // parallel pair forces zero area and no saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        done && no_triangle |-> area == '0 && !saturated)
        else $error("parallel result not zero");
    // saturation means clamped area
    assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> area == '1)
        else $error("saturated area not clamped");
    // nothing enters, so nothing leaves when that slot reaches the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##PIPE_LATENCY !done)
        else $error("spurious result");
endmodule

### tb/tb_triangle_area_from_three_lines.sv
`timescale 1ns / 1ps
// Testbench for triangle_area_from_three_lines: drives line triples and checks
// each area / no_triangle / saturated result against an exact integer predictor.
// Depends on tri_pkg and the triangle_area_from_three_lines RTL.
module tb_triangle_area_from_three_lines
    import tri_pkg::*;
();

    localparam int CW        = COEF_WIDTH_DEF;
    localparam int LATENCY   = PIPE_LATENCY;
    localparam int MAX_CYCLES = 400000;

    typedef logic signed [CW-1:0] coef_t;

    typedef struct packed {
        logic [AREA_WIDTH-1:0] area;
        logic                  no_triangle;
        logic                  saturated;
    } area_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    coef_t line1_a = '0, line1_b = '0, line1_c = '0;
    coef_t line2_a = '0, line2_b = '0, line2_c = '0;
    coef_t line3_a = '0, line3_b = '0, line3_c = '0;
    logic done;
    logic [AREA_WIDTH-1:0] area;
    logic no_triangle;
    logic saturated;

    area_result_t pending_areas[$];
    int  gap_pct = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_parallel = 0;
    int  n_sat = 0;
    int  n_errors = 0;
    longint cycle_count = 0;

    triangle_area_from_three_lines dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .line1_a(line1_a), .line1_b(line1_b), .line1_c(line1_c),
        .line2_a(line2_a), .line2_b(line2_b), .line2_c(line2_c),
        .line3_a(line3_a), .line3_b(line3_b), .line3_c(line3_c),
        .done(done), .area(area), .no_triangle(no_triangle), .saturated(saturated)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a correct run is far below this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Exact predictor. Cross products fit in 34 bits, the determinant in 51,
    // so D^2 * 2^16 and the denominator stay well inside 256 bits.
    function automatic area_result_t predict_area(coef_t a1, coef_t b1, coef_t c1,
                                                  coef_t a2, coef_t b2, coef_t c2,
                                                  coef_t a3, coef_t b3, coef_t c3);
        area_result_t r;
        logic signed [63:0] x12, x13, x23;
        logic signed [255:0] d, den;
        logic [255:0] num, quo;
        x12 = 64'(a1) * 64'(b2) - 64'(a2) * 64'(b1);
        x13 = 64'(a1) * 64'(b3) - 64'(a3) * 64'(b1);
        x23 = 64'(a2) * 64'(b3) - 64'(a3) * 64'(b2);
        r = '0;
        if (x12 == 0 || x13 == 0 || x23 == 0)
        begin
            r.no_triangle = 1'b1;
            return r;
        end
        d = 256'(c1) * 256'(x23) - 256'(c2) * 256'(x13) + 256'(c3) * 256'(x12);
        num = (d * d) << FRAC_BITS;
        den = 256'(x12) * 256'(x13) * 256'(x23);
        if (den < 0)
            den = -den;
        den = den << 1;
        quo = num / den;
        if (quo[255:AREA_WIDTH] != 0)
        begin
            r.area = '1;
            r.saturated = 1'b1;
        end
        else
            r.area = quo[AREA_WIDTH-1:0];
        return r;
    endfunction

    // Result checker: every done strobe must match the oldest expectation.
    always @(posedge clk)
    begin
        area_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_areas.size() == 0)
            begin
                $error("unexpected result: area=%0h", area);
                n_errors++;
            end
            else
            begin
                exp_r = pending_areas.pop_front();
                if (area !== exp_r.area)
                begin
                    $error("area: expected %0h, got %0h", exp_r.area, area);
                    n_errors++;
                end
                if (no_triangle !== exp_r.no_triangle)
                begin
                    $error("no_triangle: expected %0b, got %0b", exp_r.no_triangle, no_triangle);
                    n_errors++;
                end
                if (saturated !== exp_r.saturated)
                begin
                    $error("saturated: expected %0b, got %0b", exp_r.saturated, saturated);
                    n_errors++;
                end
                n_checked++;
            end
        end
    end

    // Sends one transaction; start stays high across back-to-back sends.
    task automatic send_lines(coef_t a1, coef_t b1, coef_t c1,
                              coef_t a2, coef_t b2, coef_t c2,
                              coef_t a3, coef_t b3, coef_t c3);
        area_result_t e;
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        line1_a <= a1; line1_b <= b1; line1_c <= c1;
        line2_a <= a2; line2_b <= b2; line2_c <= c2;
        line3_a <= a3; line3_b <= b3; line3_c <= c3;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        e = predict_area(a1, b1, c1, a2, b2, c2, a3, b3, c3);
        pending_areas.push_back(e);
        n_sent++;
        if (e.no_triangle)
            n_parallel++;
        if (e.saturated)
            n_sat++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_areas.size() != 0)
            @(negedge clk);
    endtask

    function automatic coef_t rand_coef(int mode);
        case (mode)
            0: return coef_t'($urandom);
            1: return coef_t'($urandom_range(16) - 8);
            2: return coef_t'($urandom_range(600) - 300);
            default: return $urandom_range(1) ? coef_t'(16'h7fff - $urandom_range(3))
                                               : coef_t'(16'h8000 + $urandom_range(3));
        endcase
    endfunction

    // Extremes, parallel pairs, concurrent lines and nearly parallel lines.
    task automatic test_directed();
        coef_t mx, mn;
        mx = coef_t'(16'h7fff);
        mn = coef_t'(16'h8000);
        send_lines(1, 0, 0, 0, 1, 0, 1, 1, -1);        // unit right triangle
        send_lines(1, 0, 0, 0, 1, 0, 1, 1, -4);
        send_lines(1, 0, 0, 0, 1, 0, 1, 1, 0);         // concurrent lines
        send_lines(1, 2, 3, 2, 4, 5, 1, -1, 0);        // lines 1,2 parallel
        send_lines(1, 2, 3, 1, -1, 0, 2, 4, 9);        // lines 1,3 parallel
        send_lines(1, -1, 0, 1, 2, 3, 2, 4, 9);        // lines 2,3 parallel
        send_lines(1, 0, 0, 2, 0, 1, 3, 0, 5);         // all parallel
        send_lines(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_lines(mx, mx, mx, mn, mn, mn, mx, mn, mx);
        send_lines(mn, mn, mn, mx, mn, mx, mn, mx, mx);
        send_lines(1, 0, mx, 0, 1, mn, 1, 1, mx);
        send_lines(1, 1, mx, 1, -1, mn, 2, 1, mx);     // tiny area, no clamp
        send_lines(mx, mx - coef_t'(1), mn, mx - coef_t'(1), mx - coef_t'(2), mx,
                   1, 1, mx);                          // nearly parallel
        send_lines(mx, 1, mn, mx, 2, mx, mx, 3, mn);   // equal a coefficients, not parallel
        send_lines(1, 0, mx, 1, 1, mn, 1, 2, mx);
        send_lines(-1, -1, -1, 1, -1, 1, -1, 1, 1);
        send_lines(mn, 1, 0, 1, mn, 0, mx, mx, mn);
        drain_results();
    endtask

    // Random triples with mixed magnitude profiles per coefficient.
    task automatic test_random(int count, int pct);
        coef_t c[9];
        gap_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            for (int k = 0; k < 9; k++)
                c[k] = rand_coef($urandom_range(3));
            // sometimes force a parallel pair
            if ($urandom_range(9) == 0)
            begin
                c[3] = c[0] * coef_t'($urandom_range(2) - 1);
                c[4] = c[1] * coef_t'($urandom_range(2) - 1);
            end
            send_lines(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
        end
    endtask

    // Sender holds off until the pipeline has fully emptied.
    task automatic test_drain_pause();
        gap_pct = 0;
        test_random(20, 0);
        drain_results();
        repeat (LATENCY) @(negedge clk);
        test_random(20, 0);
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(600, 31);
        test_random(600, 71);
        test_drain_pause();
        test_random(560, 0);
        drain_results();
        repeat (LATENCY + 5) @(negedge clk);
        $display("Covered %0d transactions, %0d checked: %0d parallel, %0d clamped.",
                 n_sent, n_checked, n_parallel, n_sat);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### sim.f
hw/rtl/tri_pkg.sv
hw/rtl/tri_front.sv
hw/rtl/tri_div.sv
hw/rtl/triangle_area_from_three_lines.sv
tb/tb_triangle_area_from_three_lines.sv
